### rtl/three_way_sorted_intersection_top_macros.svh
// assertion macros used by the rtl top level of the three-way intersection block
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef THREE_WAY_SORTED_INTERSECTION_TOP_MACROS_SVH
`define THREE_WAY_SORTED_INTERSECTION_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TSI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define TSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tsi_pkg.sv
// shared types and constants of the three-way sorted intersection block
// no dependencies
package tsi_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 32;
  localparam int unsigned MAX_RESULTS    = 32;
  localparam int unsigned VALUE_W        = 32;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_LOAD_C = 2'd2,
    KIND_RUN    = 2'd3
  } kind_e;

endpackage

### rtl/tsi_in_if.sv
// input channel of the intersection block: load and run words
// depends on tsi_pkg
interface tsi_in_if;
  import tsi_pkg::*;

  logic                       valid;
  logic                       ready;
  kind_e                      kind;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

### rtl/tsi_out_if.sv
// result channel of the intersection block
// depends on tsi_pkg
interface tsi_out_if;
  import tsi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  common_value;
  logic                       found;
  logic                       last;
  logic                       overflowed;

  modport source (output valid, output common_value, output found, output last,
                  output overflowed, input ready);
  modport sink   (input valid, input common_value, input found, input last,
                  input overflowed, output ready);
endinterface

### rtl/tsi_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tsi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/three_way_sorted_intersection_top.sv
// top level of the three-way sorted intersection block
// depends on tsi_pkg, tsi_in_if, tsi_out_if, tsi_ram and the macros header
//
// in_i carries words of kind load a, load b, load c or run. a load word appends
// value to its list; a load into a full list is dropped and sets
// the overflow flag. a run word starts the walk, and in_i.ready stays low until
// the walk has handed its final result to the output register.
// out_o gives one result per common value, ascending for sorted lists, at most
// MAX_RESULTS per run; the final one carries last. with nothing common a single
// result with found low and last high is given. overflowed reports the overflow
// flag of the data set; after a run the counts and the flag are cleared.
// each pointer step of a run is a registered ram read followed by a compare: the
// shared comparator for the merge, or a compare against the held value while
// skipping duplicates. a result is held back until the next one is found, so last
// can be marked. a stalled receiver pauses the walk when a new match finds both
// the held result and the output register full, and holds the wrap-up until the
// output register is free.
// rst_ni clears counts, flag, sequencer and output valid; list contents need no
// clearing since only loaded entries are ever read.
`include "three_way_sorted_intersection_top_macros.svh"

module three_way_sorted_intersection_top #(
  parameter int unsigned LIST_DEPTH = tsi_pkg::LIST_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsi_in_if.sink    in_i,
  tsi_out_if.source out_o
);
  import tsi_pkg::*;

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned RW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SKRD,
    ST_SKCMP,
    ST_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d, cnt_c_q, cnt_c_d;
  logic [CW-1:0]             ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d, ptr_c_q, ptr_c_d;
  logic                      ovf_q, ovf_d;
  logic [RW-1:0]             res_cnt_q, res_cnt_d;
  logic                      hold_valid_q, hold_valid_d;
  logic signed [VALUE_W-1:0] hold_value_q, hold_value_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic                      out_found_q, out_found_d;
  logic                      out_last_q, out_last_d;
  logic                      out_ovf_q, out_ovf_d;

  logic                      in_acc;
  logic                      we_a, we_b, we_c;
  logic [VALUE_W-1:0]        rd_a, rd_b, rd_c;
  logic signed [VALUE_W-1:0] a_s, b_s, c_s;
  logic                      out_free;
  logic                      walk_end;
  logic                      eq_abc, lt_ab, lt_bc;
  logic                      adv_a, adv_b, adv_c;
  logic                      walking, ptrs_ok, res_cnt_ok, done_go, last_out;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign we_a = in_acc && (in_i.kind == KIND_LOAD_A) && (cnt_a_q < CW'(LIST_DEPTH));
  assign we_b = in_acc && (in_i.kind == KIND_LOAD_B) && (cnt_b_q < CW'(LIST_DEPTH));
  assign we_c = in_acc && (in_i.kind == KIND_LOAD_C) && (cnt_c_q < CW'(LIST_DEPTH));

  // loads write at the count, the walk reads at the pointer
  tsi_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (ptr_a_q[AW-1:0]),
    .rdata_o (rd_a)
  );

  tsi_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (ptr_b_q[AW-1:0]),
    .rdata_o (rd_b)
  );

  tsi_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_c (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (cnt_c_q[AW-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (ptr_c_q[AW-1:0]),
    .rdata_o (rd_c)
  );

  assign a_s = $signed(rd_a);
  assign b_s = $signed(rd_b);
  assign c_s = $signed(rd_c);

  // shared comparator for the merge step
  assign walk_end = (ptr_a_q >= cnt_a_q) || (ptr_b_q >= cnt_b_q) || (ptr_c_q >= cnt_c_q);
  assign eq_abc   = (a_s == b_s) && (b_s == c_s);
  assign lt_ab    = a_s < b_s;
  assign lt_bc    = b_s < c_s;

  // duplicate skip against the value just matched
  assign adv_a = (ptr_a_q < cnt_a_q) && (a_s == hold_value_q);
  assign adv_b = (ptr_b_q < cnt_b_q) && (b_s == hold_value_q);
  assign adv_c = (ptr_c_q < cnt_c_q) && (c_s == hold_value_q);

  always_comb begin
    state_d      = state_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    cnt_c_d      = cnt_c_q;
    ptr_a_d      = ptr_a_q;
    ptr_b_d      = ptr_b_q;
    ptr_c_d      = ptr_c_q;
    ovf_d        = ovf_q;
    res_cnt_d    = res_cnt_q;
    hold_valid_d = hold_valid_q;
    hold_value_d = hold_value_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_found_d  = out_found_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_i.kind)
            KIND_LOAD_A: begin
              if (we_a) cnt_a_d = cnt_a_q + CW'(1);
              else      ovf_d   = 1'b1;
            end
            KIND_LOAD_B: begin
              if (we_b) cnt_b_d = cnt_b_q + CW'(1);
              else      ovf_d   = 1'b1;
            end
            KIND_LOAD_C: begin
              if (we_c) cnt_c_d = cnt_c_q + CW'(1);
              else      ovf_d   = 1'b1;
            end
            KIND_RUN: begin
              ptr_a_d      = '0;
              ptr_b_d      = '0;
              ptr_c_d      = '0;
              res_cnt_d    = '0;
              hold_valid_d = 1'b0;
              state_d      = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (walk_end) begin
          state_d = ST_DONE;
        end else if (eq_abc) begin
          // a held result goes out first; wait if the output is stalled
          if (!hold_valid_q || out_free) begin
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              out_value_d = hold_value_q;
              out_found_d = 1'b1;
              out_last_d  = 1'b0;
              out_ovf_d   = ovf_q;
            end
            hold_valid_d = 1'b1;
            hold_value_d = a_s;
            res_cnt_d    = res_cnt_q + RW'(1);
            ptr_a_d      = ptr_a_q + CW'(1);
            ptr_b_d      = ptr_b_q + CW'(1);
            ptr_c_d      = ptr_c_q + CW'(1);
            if (res_cnt_q + RW'(1) == RW'(MAX_RESULTS)) state_d = ST_DONE;
            else                                        state_d = ST_SKRD;
          end
        end else begin
          if (lt_ab)      ptr_a_d = ptr_a_q + CW'(1);
          else if (lt_bc) ptr_b_d = ptr_b_q + CW'(1);
          else            ptr_c_d = ptr_c_q + CW'(1);
          state_d = ST_RD;
        end
      end
      ST_SKRD: begin
        state_d = ST_SKCMP;
      end
      ST_SKCMP: begin
        if (adv_a) ptr_a_d = ptr_a_q + CW'(1);
        if (adv_b) ptr_b_d = ptr_b_q + CW'(1);
        if (adv_c) ptr_c_d = ptr_c_q + CW'(1);
        // pointers unchanged means the read data is still current
        if (adv_a || adv_b || adv_c) state_d = ST_SKRD;
        else                         state_d = ST_CMP;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = hold_valid_q ? hold_value_q : '0;
          out_found_d  = hold_valid_q;
          out_last_d   = 1'b1;
          out_ovf_d    = ovf_q;
          hold_valid_d = 1'b0;
          cnt_a_d      = '0;
          cnt_b_d      = '0;
          cnt_c_d      = '0;
          ovf_d        = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      cnt_c_q      <= '0;
      ptr_a_q      <= '0;
      ptr_b_q      <= '0;
      ptr_c_q      <= '0;
      ovf_q        <= 1'b0;
      res_cnt_q    <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_a_q      <= cnt_a_d;
      cnt_b_q      <= cnt_b_d;
      cnt_c_q      <= cnt_c_d;
      ptr_a_q      <= ptr_a_d;
      ptr_b_q      <= ptr_b_d;
      ptr_c_q      <= ptr_c_d;
      ovf_q        <= ovf_d;
      res_cnt_q    <= res_cnt_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_value_q <= hold_value_d;
    out_value_q  <= out_value_d;
    out_found_q  <= out_found_d;
    out_last_q   <= out_last_d;
    out_ovf_q    <= out_ovf_d;
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.common_value = out_value_q;
  assign out_o.found        = out_found_q;
  assign out_o.last         = out_last_q;
  assign out_o.overflowed   = out_ovf_q;

  assign walking    = (state_q != ST_IDLE);
  assign ptrs_ok    = (ptr_a_q <= cnt_a_q) && (ptr_b_q <= cnt_b_q) && (ptr_c_q <= cnt_c_q);
  assign res_cnt_ok = (res_cnt_q <= RW'(MAX_RESULTS));
  assign done_go    = (state_q == ST_DONE) && out_free;
  assign last_out   = out_valid_q && out_last_q && (state_q == ST_IDLE);

  `TSI_ASSERT_NOW(a_ptr_in_range, clk_i, rst_ni, walking, ptrs_ok, "pointer beyond count")
  `TSI_ASSERT_NOW(a_res_cnt_max, clk_i, rst_ni, 1'b1, res_cnt_ok, "result count beyond limit")
  `TSI_ASSERT_NOW(a_hold_counted, clk_i, rst_ni, hold_valid_q, |res_cnt_q, "unmatched hold")
  `TSI_ASSERT_NOW(a_idle_no_hold, clk_i, rst_ni, !walking, !hold_valid_q, "hold left after run")
  `TSI_ASSERT_NEXT(a_done_last, clk_i, rst_ni, done_go, last_out, "run ended without last")

endmodule

### verif/tb_three_way_sorted_intersection_top.sv
// testbench for the three-way sorted intersection block: clocked driver and monitor
// around the top level, with a predictor of the list merge and a store of expected results
// depends on tsi_pkg, tsi_in_if, tsi_out_if and three_way_sorted_intersection_top
`timescale 1ns / 1ps

module tb_three_way_sorted_intersection_top;
  import tsi_pkg::*;

  localparam int unsigned LIST_DEPTH   = LIST_DEPTH_DEF;
  localparam int          TARGET_WORDS = 200;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 250;
  localparam int          CYCLE_LIMIT  = 300000;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {SET_SORTED, SET_NOISE, SET_SAME} set_shape_e;

  typedef struct {
    kind_e                      kind;
    logic signed [VALUE_W-1:0]  value;
  } in_word_t;

  typedef struct {
    logic signed [VALUE_W-1:0]  common_value;
    logic                       found;
    logic                       last;
    logic                       overflowed;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_n;

  tsi_in_if  in_if ();
  tsi_out_if out_if ();

  three_way_sorted_intersection_top #(
    .LIST_DEPTH(LIST_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state: one copy of each list, its fill count and the overflow flag
  logic signed [VALUE_W-1:0] list_mem [3][LIST_DEPTH];
  int unsigned               list_len [3] = '{0, 0, 0};
  logic                      list_overflow = 1'b0;

  in_word_t pending_words [$];
  match_t   expected_results [$];

  int mismatches     = 0;
  int cycle_count    = 0;
  int words_accepted = 0;
  int total_words    = 0;
  int hold_after     = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int tx_wait        = 0;
  int tx_calm        = 0;
  int rx_wait        = 0;
  int rx_calm        = 0;
  in_word_t tx_word;

  // feed one accepted word to the predictor; a run queues its results
  task automatic ingest_word(kind_e kind, logic signed [VALUE_W-1:0] value);
    int unsigned ia, ib, ic, nres;
    logic signed [VALUE_W-1:0] a, b, c;
    match_t prev;
    bit have_prev;
    if (kind != KIND_RUN) begin
      if (list_len[int'(kind)] < LIST_DEPTH) begin
        list_mem[int'(kind)][list_len[int'(kind)]] = value;
        list_len[int'(kind)]++;
      end else begin
        list_overflow = 1'b1;
      end
    end else begin
      ia = 0;
      ib = 0;
      ic = 0;
      nres = 0;
      have_prev = 1'b0;
      while (ia < list_len[0] && ib < list_len[1] && ic < list_len[2] && nres < MAX_RESULTS)
      begin
        a = list_mem[0][ia];
        b = list_mem[1][ib];
        c = list_mem[2][ic];
        if (a == b && b == c) begin
          // hold each hit back so the final one can carry last
          if (have_prev) expected_results.insert(expected_results.size(), prev);
          prev = '{a, 1'b1, 1'b0, list_overflow};
          have_prev = 1'b1;
          nres++;
          while (ia < list_len[0] && list_mem[0][ia] == a) ia++;
          while (ib < list_len[1] && list_mem[1][ib] == a) ib++;
          while (ic < list_len[2] && list_mem[2][ic] == a) ic++;
        end else if (a < b) begin
          ia++;
        end else if (b < c) begin
          ib++;
        end else begin
          ic++;
        end
      end
      if (!have_prev) prev = '{'0, 1'b0, 1'b1, list_overflow};
      else prev.last = 1'b1;
      expected_results.insert(expected_results.size(), prev);
      list_len = '{0, 0, 0};
      list_overflow = 1'b0;
    end
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("cycle %0d: mismatch on %s: got %0d, expected %0d", cycle_count, field, got, want);
  endtask

  task automatic check_result();
    match_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("common_value of unexpected word", out_if.common_value, 0);
      return;
    end
    want = expected_results.pop_front();
    if (out_if.common_value !== want.common_value)
      report_mismatch("common_value", out_if.common_value, want.common_value);
    if (out_if.found !== want.found) report_mismatch("found", out_if.found, want.found);
    if (out_if.last !== want.last) report_mismatch("last", out_if.last, want.last);
    if (out_if.overflowed !== want.overflowed)
      report_mismatch("overflowed", out_if.overflowed, want.overflowed);
  endtask

  // per-word wait, with occasional stretches of back-to-back words
  function automatic int pick_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = 24;
    return $urandom_range(0, 8);
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(30, 34);
    return $urandom_range(0, 10);
  endfunction

  task automatic push_word(kind_e kind, logic signed [VALUE_W-1:0] value);
    in_word_t w;
    w.kind = kind;
    w.value = value;
    pending_words.insert(pending_words.size(), w);
  endtask

  // one data set: three lists loaded in random interleaving, then a run
  task automatic add_set(set_shape_e shape, int na, int nb, int nc);
    logic signed [VALUE_W-1:0] src [3][$];
    int len [3];
    longint base, v;
    int l, e, pick;
    len = '{na, nb, nc};
    base = longint'($signed($urandom));
    if (base > 64'sd2147483647 - 200) base = base - 200;
    for (l = 0; l < 3; l++) begin
      if (shape == SET_SAME && l > 0) begin
        src[l] = src[0];
      end else begin
        v = base;
        if (shape == SET_SORTED) v = base + $urandom_range(0, 3);
        for (e = 0; e < len[l]; e++) begin
          case (shape)
            SET_SORTED: begin
              src[l].insert(src[l].size(), v[VALUE_W-1:0]);
              v = v + $urandom_range(0, 2);
            end
            SET_SAME: begin
              src[l].insert(src[l].size(), v[VALUE_W-1:0]);
              v = v + $urandom_range(1, 3);
            end
            default: begin
              if ($urandom_range(0, 1) != 0) src[l].insert(src[l].size(), $urandom);
              else src[l].insert(src[l].size(), $urandom_range(0, 3));
            end
          endcase
        end
      end
    end
    while (src[0].size() + src[1].size() + src[2].size() != 0) begin
      pick = $urandom_range(0, 2);
      if (src[pick].size() != 0) push_word(kind_e'(pick), src[pick].pop_front());
    end
    push_word(KIND_RUN, $urandom);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[three_way_sorted_intersection_top] ERROR");
      $finish;
    end
  end

  // driver: offers pending words, predicts each one at acceptance
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        ingest_word(in_if.kind, in_if.value);
        words_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          tx_word = pending_words.pop_front();
          in_if.kind  <= tx_word.kind;
          in_if.value <= tx_word.value;
          in_if.valid <= 1'b1;
          tx_wait = pick_gap(tx_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off once the big set starts producing results
  always @(posedge clk_i) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && out_if.valid && words_accepted >= hold_after) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks accepted results and paces ready
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_result();
        rx_wait = pick_gap(rx_calm);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_if.ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  initial begin
    int r, n;
    in_if.valid  = 1'b0;
    in_if.kind   = KIND_LOAD_A;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    rst_n        = 1'b0;

    // all lists empty
    push_word(KIND_RUN, '0);
    // value extremes and duplicates in common
    push_word(KIND_LOAD_A, VAL_MIN);
    push_word(KIND_LOAD_B, VAL_MIN);
    push_word(KIND_LOAD_C, VAL_MIN);
    push_word(KIND_LOAD_A, -32'sd1);
    push_word(KIND_LOAD_B, 32'sd0);
    push_word(KIND_LOAD_C, 32'sd0);
    push_word(KIND_LOAD_A, 32'sd0);
    push_word(KIND_LOAD_B, 32'sd0);
    push_word(KIND_LOAD_C, VAL_MAX);
    push_word(KIND_LOAD_A, VAL_MAX);
    push_word(KIND_LOAD_B, VAL_MAX);
    push_word(KIND_LOAD_C, VAL_MAX);
    push_word(KIND_RUN, VAL_MAX);
    // unsorted lists
    push_word(KIND_LOAD_A, 32'sd5);
    push_word(KIND_LOAD_B, 32'sd1);
    push_word(KIND_LOAD_C, 32'sd5);
    push_word(KIND_LOAD_A, 32'sd1);
    push_word(KIND_LOAD_B, 32'sd5);
    push_word(KIND_LOAD_C, 32'sd1);
    push_word(KIND_RUN, -32'sd1);
    // one list left empty
    push_word(KIND_LOAD_A, 32'sd3);
    push_word(KIND_LOAD_B, 32'sd3);
    push_word(KIND_RUN, '0);

    // full lists with every value common: fills the result path under the hold-off
    add_set(SET_SAME, LIST_DEPTH, LIST_DEPTH, LIST_DEPTH);
    hold_after = pending_words.size();
    add_set(SET_SORTED, LIST_DEPTH + 1, 2, 2);
    while (pending_words.size() < TARGET_WORDS) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        add_set(SET_SORTED, pick_len(), pick_len(), pick_len());
      end else if (r < 8) begin
        add_set(SET_NOISE, pick_len(), pick_len(), pick_len());
      end else begin
        n = $urandom_range(1, 8);
        add_set(SET_SAME, n, n, n);
      end
    end
    total_words = pending_words.size();

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    wait (words_accepted == total_words);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[three_way_sorted_intersection_top] OK");
    end else begin
      $display("[three_way_sorted_intersection_top] ERROR");
    end
    $finish;
  end

endmodule

### three_way_sorted_intersection_top.f
+incdir+rtl
rtl/tsi_pkg.sv
rtl/tsi_in_if.sv
rtl/tsi_out_if.sv
rtl/tsi_ram.sv
rtl/three_way_sorted_intersection_top.sv
verif/tb_three_way_sorted_intersection_top.sv
